// File: hw/rtl/multi_owner_heartbeat_supervisor_core_macros.svh
// Assertion macros for the heartbeat supervisor, clocked on clk_i, disabled in reset.
`ifndef MULTI_OWNER_HEARTBEAT_SUPERVISOR_CORE_MACROS_SVH
`define MULTI_OWNER_HEARTBEAT_SUPERVISOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define MOHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("heartbeat supervisor assertion failed");
`define MOHS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("heartbeat supervisor forbidden condition");
`else
`define MOHS_ASSERT(lbl, prop)
`define MOHS_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: hw/rtl/mohs_pkg.sv
// Types, codes and constants shared by the heartbeat supervisor files.
package mohs_pkg;

  localparam int OWNERS    = 8;
  localparam int ID_W      = 4;
  localparam int OWN_IDX_W = 3;
  localparam int LIM_W     = 16;
  localparam int CNT_W     = 32;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [ID_W-1:0] NONE_OWNER = ID_W'(8);

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_REPORT   = 2'd1;
  localparam logic [1:0] CMD_CHECK    = 2'd2;
  localparam logic [1:0] CMD_BOOT_RDY = 2'd3;

  localparam logic [1:0] PH_BOOT  = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_FLASH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_INDEX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAPHICS_INDEX = 3'd4;

  localparam logic [LIM_W-1:0]     RST_NORMAL_LIMIT   = 16'd1000;
  localparam logic [LIM_W-1:0]     RST_STORAGE_LIMIT  = 16'd2000;
  localparam logic [LIM_W-1:0]     RST_SLOW_LIMIT     = 16'd2500;
  localparam logic [OWN_IDX_W-1:0] RST_STORAGE_INDEX  = 3'd0;
  localparam logic [OWN_IDX_W-1:0] RST_GRAPHICS_INDEX = 3'd1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_REGISTER,
    OP_REPORT,
    OP_REBASE
  } op_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [2:0]        owner;
    logic [TIME_W-1:0] now;
    logic              sleeping;
    logic [1:0]        phase;
    logic [31:0]       flash_count;
  } item_t;

  typedef struct packed {
    logic             checked;
    logic             fault_now;
    logic [ID_W-1:0]  latched_owner;
    logic             enter_run;
    logic [CNT_W-1:0] check_count;
    logic [CNT_W-1:0] progress_count;
  } result_t;

  // deadline selection, broadcast to every cell
  typedef struct packed {
    logic [LIM_W-1:0]     normal;
    logic [LIM_W-1:0]     storage;
    logic [LIM_W-1:0]     slow;
    logic [OWN_IDX_W-1:0] storage_idx;
    logic [OWN_IDX_W-1:0] graphics_idx;
    logic                 sleep;
  } lim_t;

  // per-item command broadcast to every cell
  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
    logic              fail_latch;
    logic              flash_match;
    logic              boot;
  } bcast_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic            valid;
    logic            fault;
    logic [ID_W-1:0] fail_id;
    logic            all_rep;
  } tok_t;

  // cell status seen by the controller
  typedef struct packed {
    logic             registered;
    logic [CNT_W-1:0] count;
    logic             late;
  } stat_t;

endpackage

// File: hw/rtl/mohs_cell.sv
// One owner cell: registration bit, stamp, report count and one scan step.
module mohs_cell import mohs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] cell_idx_i,
  input  lim_t            lim_i,
  input  bcast_t          bc_i,
  input  tok_t            tok_i,
  output tok_t            tok_o,
  output stat_t           stat_o
);

  logic              reg_q, reg_d;
  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic [CNT_W-1:0]  count_q, count_d;
  tok_t              tok_q, tok_d;

  logic [LIM_W-1:0]  limit;
  logic [TIME_W-1:0] elapsed;
  logic              late;
  logic              hit;
  logic              count_zero;

  always_comb begin
    if (cell_idx_i == {1'b0, lim_i.storage_idx}) begin
      limit = lim_i.storage;
    end else if (cell_idx_i == {1'b0, lim_i.graphics_idx} || lim_i.sleep) begin
      limit = lim_i.slow;
    end else begin
      limit = lim_i.normal;
    end
  end

  assign elapsed    = bc_i.now - stamp_q;
  assign late       = elapsed > {{(TIME_W-LIM_W){1'b0}}, limit};
  assign hit        = bc_i.id == cell_idx_i;
  assign count_zero = count_q == '0;

  always_comb begin
    reg_d   = reg_q;
    stamp_d = stamp_q;
    count_d = count_q;
    unique case (bc_i.op)
      OP_REGISTER: begin
        if (hit && !reg_q) begin
          reg_d   = 1'b1;
          stamp_d = bc_i.now;
        end
      end
      OP_REPORT: begin
        if (hit && reg_q && !bc_i.fail_latch &&
            !(!count_zero && bc_i.flash_match && late)) begin
          stamp_d = bc_i.now;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REBASE: begin
        if (reg_q) begin
          stamp_d = bc_i.now;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && reg_q) begin
      if (count_zero) begin
        tok_d.all_rep = 1'b0;
      end
      if (!tok_i.fault && !(count_zero && bc_i.boot) && late) begin
        tok_d.fault   = 1'b1;
        tok_d.fail_id = cell_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q   <= 1'b0;
      count_q <= '0;
      tok_q   <= '0;
    end else begin
      reg_q   <= reg_d;
      count_q <= count_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
  end

  assign tok_o             = tok_q;
  assign stat_o.registered = reg_q;
  assign stat_o.count      = count_q;
  assign stat_o.late       = late;

endmodule

// File: hw/rtl/multi_owner_heartbeat_supervisor_core.sv
// Heartbeat supervisor top level: command sequencer, limits and the row of owner cells.
// Register, report and boot-ready items pass through PREP and DONE before their result strobe.
// A check that scans also passes through SCAN, where the scan token walks
// the cell row one owner per cycle. busy drops in the strobe cycle; no new item is taken before then.
// Reset clears registrations, counts, flags and the failure latch and loads default limits.
`include "multi_owner_heartbeat_supervisor_core_macros.svh"

module multi_owner_heartbeat_supervisor_core import mohs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e  state_q;
  item_t   item_q;
  lim_t    lim_q;
  logic    inject_q;
  logic    boot_rdy_q;
  logic    fail_latch_q;
  logic [ID_W-1:0]  fail_owner_q;
  logic [CNT_W-1:0] pass_q;
  logic [31:0]      flash_ref_q;
  logic    chk_q, fault_q, run_q;
  logic    result_valid_q;
  result_t result_q;

  bcast_t bc;
  tok_t   tok [OWNERS+1];
  stat_t  stat [OWNERS];
  stat_t  sel;
  logic   own_ok;
  logic   flash_match;
  logic   report_fault;
  logic   check_go;
  tok_t   tok_end;

  assign own_ok       = {1'b0, item_q.owner} < ID_W'(OWNERS);
  assign sel          = stat[item_q.owner];
  assign flash_match  = flash_ref_q == item_q.flash_count;
  assign report_fault = own_ok && sel.registered && !fail_latch_q &&
                        sel.count != '0 && flash_match && sel.late;
  assign check_go     = !fail_latch_q && item_q.phase != PH_FLASH;
  assign tok_end      = tok[OWNERS];

  always_comb begin
    bc.op          = OP_NONE;
    bc.id          = {1'b0, item_q.owner};
    bc.now         = item_q.now;
    bc.fail_latch  = fail_latch_q;
    bc.flash_match = flash_match;
    bc.boot        = item_q.phase == PH_BOOT;
    if (state_q == ST_PREP) begin
      unique case (item_q.cmd)
        CMD_REGISTER: bc.op = own_ok ? OP_REGISTER : OP_NONE;
        CMD_REPORT:   bc.op = own_ok ? OP_REPORT : OP_NONE;
        CMD_CHECK:    bc.op = (check_go && !flash_match) ? OP_REBASE : OP_NONE;
        default:      bc.op = OP_NONE;
      endcase
    end
  end

  assign tok[0].valid   = inject_q;
  assign tok[0].fault   = 1'b0;
  assign tok[0].fail_id = NONE_OWNER;
  assign tok[0].all_rep = 1'b1;

  for (genvar i = 0; i < OWNERS; i++) begin : g_cell
    mohs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (ID_W'(i)),
      .lim_i      (lim_q),
      .bc_i       (bc),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .stat_o     (stat[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.normal       <= RST_NORMAL_LIMIT;
      lim_q.storage      <= RST_STORAGE_LIMIT;
      lim_q.slow         <= RST_SLOW_LIMIT;
      lim_q.storage_idx  <= RST_STORAGE_INDEX;
      lim_q.graphics_idx <= RST_GRAPHICS_INDEX;
      lim_q.sleep        <= 1'b0;
      state_q        <= ST_IDLE;
      item_q         <= '0;
      inject_q       <= 1'b0;
      boot_rdy_q     <= 1'b0;
      fail_latch_q   <= 1'b0;
      fail_owner_q   <= NONE_OWNER;
      pass_q         <= '0;
      flash_ref_q    <= '0;
      chk_q          <= 1'b0;
      fault_q        <= 1'b0;
      run_q          <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      inject_q       <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NORMAL_LIMIT:   lim_q.normal       <= cfg_data_i;
          CFG_STORAGE_LIMIT:  lim_q.storage      <= cfg_data_i;
          CFG_SLOW_LIMIT:     lim_q.slow         <= cfg_data_i;
          CFG_STORAGE_INDEX:  lim_q.storage_idx  <= cfg_data_i[OWN_IDX_W-1:0];
          CFG_GRAPHICS_INDEX: lim_q.graphics_idx <= cfg_data_i[OWN_IDX_W-1:0];
          default: begin
          end
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            item_q  <= item_i;
            chk_q   <= 1'b0;
            fault_q <= 1'b0;
            run_q   <= 1'b0;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_DONE;
          unique case (item_q.cmd)
            CMD_REPORT: begin
              if (report_fault) begin
                fail_latch_q <= 1'b1;
                fail_owner_q <= {1'b0, item_q.owner};
                fault_q      <= 1'b1;
              end
            end
            CMD_CHECK: begin
              if (check_go) begin
                lim_q.sleep  <= item_q.sleeping;
                flash_ref_q  <= item_q.flash_count;
                inject_q     <= 1'b1;
                state_q      <= ST_SCAN;
              end
            end
            CMD_BOOT_RDY: boot_rdy_q <= 1'b1;
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          if (tok_end.valid) begin
            state_q <= ST_DONE;
            if (tok_end.fault) begin
              fail_latch_q <= 1'b1;
              fail_owner_q <= tok_end.fail_id;
              fault_q      <= 1'b1;
            end else begin
              pass_q <= pass_q + CNT_W'(1);
              chk_q  <= 1'b1;
              run_q  <= tok_end.all_rep && boot_rdy_q && item_q.phase == PH_BOOT;
            end
          end
        end
        ST_DONE: begin
          state_q                 <= ST_IDLE;
          result_valid_q          <= 1'b1;
          result_q.checked        <= chk_q;
          result_q.fault_now      <= fault_q;
          result_q.latched_owner  <= fail_owner_q;
          result_q.enter_run      <= run_q;
          result_q.check_count    <= pass_q;
          result_q.progress_count <= own_ok ? sel.count : '0;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `MOHS_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o)
  `MOHS_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `MOHS_ASSERT(a_fault_owner, (result_valid_o && result_o.fault_now) |-> (result_o.latched_owner != NONE_OWNER))
  `MOHS_ASSERT_NEVER(a_check_and_fault, result_valid_o && result_o.checked && result_o.fault_now)
  `MOHS_ASSERT(a_run_needs_check, (result_valid_o && result_o.enter_run) |-> result_o.checked)
  `MOHS_ASSERT(a_latch_holds, fail_latch_q |=> (fail_latch_q && $stable(fail_owner_q)))

endmodule
